// ----- sv/dlob_pkg.sv -----
// Shared types and constants of the door-left-open beep timer.
package dlob_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int DELAY_REG_WIDTH = 16;

   localparam logic [15:0] OPEN_DELAY_RESET        = 16'd30000;
   localparam logic [7:0]  BURST_REPEATS_RESET     = 8'd5;
   localparam logic [7:0]  TICKS_PER_PERIOD_RESET  = 8'd98;
   localparam logic [7:0]  PERIODS_PER_BURST_RESET = 8'd10;
   localparam logic [7:0]  BURSTS_UNLIMITED        = 8'd255;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLED           = 3'd0,
      CSR_OPEN_DELAY_MS     = 3'd1,
      CSR_BURST_REPEATS     = 3'd2,
      CSR_TICKS_PER_PERIOD  = 3'd3,
      CSR_PERIODS_PER_BURST = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                       enabled;
      logic [DELAY_REG_WIDTH-1:0] open_delay_ms;
      logic [7:0]                 burst_repeats;
      logic [7:0]                 ticks_per_period;
      logic [7:0]                 periods_per_burst;
   } cfg_type;

   typedef struct packed {
      logic ms_strobe;
      logic beep_strobe;
      logic door_closed;
      logic star_pressed;
   } req_type;

   typedef struct packed {
      logic       beep_drive;
      logic [7:0] bursts_left;
      logic       is_inhibited;
   } rsp_type;

endpackage

// ----- sv/dlob_ifs.sv -----
// Channel interfaces: request, response and register write.
interface dlob_req_if;
   logic valid;
   logic ready;
   logic ms_strobe;
   logic beep_strobe;
   logic door_closed;
   logic star_pressed;
   modport source (output valid, ms_strobe, beep_strobe, door_closed, star_pressed,
                   input ready);
   modport sink (input valid, ms_strobe, beep_strobe, door_closed, star_pressed,
                 output ready);
endinterface

interface dlob_rsp_if;
   logic       valid;
   logic       ready;
   logic       beep_drive;
   logic [7:0] bursts_left;
   logic       is_inhibited;
   modport source (output valid, beep_drive, bursts_left, is_inhibited, input ready);
   modport sink (input valid, beep_drive, bursts_left, is_inhibited, output ready);
endinterface

interface dlob_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dlob_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [dlob_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/dlob_csr.sv -----
// Configuration register file.
module dlob_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [dlob_pkg::CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [dlob_pkg::CSR_DATA_WIDTH-1:0]  wr_data,
   output dlob_pkg::cfg_type                    cfg
);

   dlob_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled           <= 1'b0;
         cfg_ff.open_delay_ms     <= dlob_pkg::OPEN_DELAY_RESET;
         cfg_ff.burst_repeats     <= dlob_pkg::BURST_REPEATS_RESET;
         cfg_ff.ticks_per_period  <= dlob_pkg::TICKS_PER_PERIOD_RESET;
         cfg_ff.periods_per_burst <= dlob_pkg::PERIODS_PER_BURST_RESET;
      end else if (wr_en) begin
         unique case (dlob_pkg::csr_index_type'(wr_index))
            dlob_pkg::CSR_ENABLED:           cfg_ff.enabled           <= wr_data[0];
            dlob_pkg::CSR_OPEN_DELAY_MS:     cfg_ff.open_delay_ms     <= wr_data;
            dlob_pkg::CSR_BURST_REPEATS:     cfg_ff.burst_repeats     <= wr_data[7:0];
            dlob_pkg::CSR_TICKS_PER_PERIOD:  cfg_ff.ticks_per_period  <= wr_data[7:0];
            dlob_pkg::CSR_PERIODS_PER_BURST: cfg_ff.periods_per_burst <= wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/dlob_engine.sv -----
// Trigger and burst state with its one-step update logic.
module dlob_engine #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dlob_pkg::req_type item,
   input  dlob_pkg::cfg_type cfg,
   output dlob_pkg::rsp_type result
);

   localparam int KEEP = (DELAY_WIDTH < dlob_pkg::DELAY_REG_WIDTH) ?
                         DELAY_WIDTH : dlob_pkg::DELAY_REG_WIDTH;

   logic [7:0]           period_count_ff, period_count_in;
   logic [7:0]           tick_count_ff, tick_count_in;
   logic [7:0]           burst_count_ff, burst_count_in;
   logic                 inhibit_ff, inhibit_in;
   logic                 door_was_open_ff, door_was_open_in;
   logic [DELAY_WIDTH:0] open_ms_ff, open_ms_in;
   logic                 beep_level_ff, beep_level_in;
   logic [DELAY_WIDTH:0] delay_ext;

   assign delay_ext = {{(DELAY_WIDTH + 1 - KEEP){1'b0}}, cfg.open_delay_ms[KEEP-1:0]};

   always_comb begin
      period_count_in  = period_count_ff;
      tick_count_in    = tick_count_ff;
      burst_count_in   = burst_count_ff;
      inhibit_in       = inhibit_ff;
      door_was_open_in = door_was_open_ff;
      open_ms_in       = open_ms_ff;
      beep_level_in    = beep_level_ff;

      if (cfg.enabled) begin
         if (item.star_pressed) begin
            inhibit_in = 1'b1;
         end
         if (item.door_closed) begin
            inhibit_in       = 1'b0;
            burst_count_in   = cfg.burst_repeats;
            door_was_open_in = 1'b0;
         end else begin
            if (!door_was_open_ff) begin
               door_was_open_in = 1'b1;
               open_ms_in       = '0;
            end else if (item.ms_strobe && open_ms_ff != '1) begin
               open_ms_in = open_ms_ff + 1'b1;
            end
            if (open_ms_in > delay_ext) begin
               if (!inhibit_in) begin
                  if (burst_count_ff != 8'd0) begin
                     period_count_in = cfg.periods_per_burst;
                     tick_count_in   = 8'd0;
                  end
                  if (burst_count_ff != 8'd0 && burst_count_ff != dlob_pkg::BURSTS_UNLIMITED) begin
                     burst_count_in = burst_count_ff - 8'd1;
                  end
               end
               open_ms_in = '0;
            end
         end
      end

      if (item.beep_strobe) begin
         if (tick_count_in != 8'd0) begin
            tick_count_in = tick_count_in - 8'd1;
         end else begin
            if (!period_count_in[0]) begin
               beep_level_in = 1'b0;
            end
            if (period_count_in != 8'd0) begin
               period_count_in = period_count_in - 8'd1;
               tick_count_in   = cfg.ticks_per_period;
               if (period_count_in[0]) begin
                  beep_level_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff  <= 8'd0;
         tick_count_ff    <= 8'd0;
         burst_count_ff   <= 8'd0;
         inhibit_ff       <= 1'b0;
         door_was_open_ff <= 1'b0;
         open_ms_ff       <= '0;
         beep_level_ff    <= 1'b0;
      end else if (advance) begin
         period_count_ff  <= period_count_in;
         tick_count_ff    <= tick_count_in;
         burst_count_ff   <= burst_count_in;
         inhibit_ff       <= inhibit_in;
         door_was_open_ff <= door_was_open_in;
         open_ms_ff       <= open_ms_in;
         beep_level_ff    <= beep_level_in;
      end
   end

   assign result.beep_drive   = beep_level_in;
   assign result.bursts_left  = burst_count_in;
   assign result.is_inhibited = inhibit_in;

endmodule

// ----- sv/door_left_open_beep_timer_core.sv -----
// Top level of the door-left-open beep timer.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | ms_strobe, beep_strobe, door_closed, star_pressed
//   rsp     | out | valid / ready | beep_drive, bursts_left, is_inhibited
//   csr     | in  | valid / ready | index, data (ready always high)
//
// One request per clock unless the response stalls; each request passes the request
// register and then the response register. The step update is one pass of logic
// between the two; the state registers update when a request moves to the response.
// Synchronous reset clears the state, the pipeline valids and loads register defaults.
// A stalled response holds the request register, and req.ready drops only then.
module door_left_open_beep_timer_core #(
   parameter int DELAY_WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   dlob_req_if.sink   req,
   dlob_rsp_if.source rsp,
   dlob_csr_if.sink   csr
);

   dlob_pkg::cfg_type cfg;
   dlob_pkg::req_type item_ff;
   dlob_pkg::rsp_type step_result;
   dlob_pkg::rsp_type rsp_ff;
   logic              in_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;

   assign csr.ready = 1'b1;

   dlob_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         item_ff.ms_strobe    <= req.ms_strobe;
         item_ff.beep_strobe  <= req.beep_strobe;
         item_ff.door_closed  <= req.door_closed;
         item_ff.star_pressed <= req.star_pressed;
      end
   end

   dlob_engine #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.beep_drive   = rsp_ff.beep_drive;
   assign rsp.bursts_left  = rsp_ff.bursts_left;
   assign rsp.is_inhibited = rsp_ff.is_inhibited;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while response stalled");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> in_valid_ff)
      else $error("accepted request lost");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("step produced no response");

endmodule
